// File: hdl/rmmd_pkg.sv
// ----------------------------------------------------------------------------
// rmmd_pkg
// Shared widths, register map and helper functions for the first-order
// Reed-Muller majority-logic decoder.
// ----------------------------------------------------------------------------
package rmmd_pkg;

    localparam int WORD_W     = 64;  // received word width
    localparam int MSG_W      = 7;   // decoded message width
    localparam int N_W        = 3;   // message_bits register width
    localparam int LEN_W      = 7;   // code length, up to 64
    localparam int PAIR_CNT_W = 6;   // up to 32 differing pairs
    localparam int MIS_CNT_W  = 7;   // up to 64 mismatches
    localparam int PAIRS      = WORD_W / 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register indexes (word addresses).
    localparam logic [0:0] REG_MESSAGE_BITS = 1'b0;

    // Code length 2^(n-1) for an already clamped n.
    function automatic logic [LEN_W-1:0] code_len(input logic [N_W-1:0] n);
        code_len = LEN_W'(1) << (n - N_W'(1));
    endfunction

    // Ones at every position below the code length.
    function automatic logic [WORD_W-1:0] len_mask(input logic [N_W-1:0] n);
        len_mask = {WORD_W{1'b1}} >> (LEN_W'(WORD_W) - code_len(n));
    endfunction

    // XOR of the pairs (p, p + 2^(i-1)) for every p whose bit i-1 is zero.
    // The q-th pair starts at q with a zero bit inserted at position i-1.
    function automatic logic [PAIRS-1:0] pair_diff(input logic [WORD_W-1:0] w,
                                                   input int i);
        int p;
        int e;
        logic [PAIRS-1:0] d;
        e = 1 << (i - 1);
        d = '0;
        for (int q = 0; q < PAIRS; q++)
        begin
            p = ((q >> (i - 1)) << i) | (q & (e - 1));
            d[q] = w[p] ^ w[p + e];
        end
        return d;
    endfunction

    // Population counts are built as balanced adder trees.
    function automatic logic [PAIR_CNT_W-1:0] popcount32(input logic [PAIRS-1:0] v);
        logic [PAIR_CNT_W-1:0] s [PAIRS];
        for (int k = 0; k < PAIRS; k++)
        begin
            s[k] = PAIR_CNT_W'(v[k]);
        end
        for (int w = PAIRS >> 1; w >= 1; w = w >> 1)
        begin
            for (int k = 0; k < w; k++)
            begin
                s[k] = s[2*k] + s[2*k+1];
            end
        end
        return s[0];
    endfunction

    function automatic logic [MIS_CNT_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [MIS_CNT_W-1:0] s [WORD_W];
        for (int k = 0; k < WORD_W; k++)
        begin
            s[k] = MIS_CNT_W'(v[k]);
        end
        for (int w = WORD_W >> 1; w >= 1; w = w >> 1)
        begin
            for (int k = 0; k < w; k++)
            begin
                s[k] = s[2*k] + s[2*k+1];
            end
        end
        return s[0];
    endfunction

    // Position p carries m0 ^ XOR over j of (mj & p[j-1]).
    // Message bits at and above n are zero, so n need not be known here.
    function automatic logic [WORD_W-1:0] encode(input logic [MSG_W-1:0] msg);
        logic [WORD_W-1:0] cw;
        logic [5:0] pv;
        logic b;
        cw = '0;
        for (int p = 0; p < WORD_W; p++)
        begin
            pv = 6'(p);
            b = msg[0];
            for (int j = 1; j < MSG_W; j++)
            begin
                b = b ^ (msg[j] & pv[j-1]);
            end
            cw[p] = b;
        end
        return cw;
    endfunction

endpackage

// File: hdl/reed_muller_majority_decoder_top.sv
// ----------------------------------------------------------------------------
// reed_muller_majority_decoder_top
// Four-stage pipelined majority-logic decoder for first-order Reed-Muller
// codes of length 2^(n-1), n taken from the message_bits register.
//
//   channel   | direction | payload
//   ----------+-----------+------------------------------------------------
//   s_axis    | in        | tdata[63:0] = received_word
//   m_axis    | out       | tdata[7:0]  = {1'b0, message[6:0]}
//   apb       | in/out    | message_bits at byte address 0, bits [2:0]
//
// One codeword is accepted per cycle while m_axis does not stall; each one
// passes through all four register stages before m_axis_tvalid shows its result.
// The four register stages are: masking, pair counting, majority vote with
// re-encoding, and mismatch count with bit-0 correction. Each stage holds its
// item while the stage after it is full and stalled, so a stall on m_axis
// backs up through the pipe without losing anything.
// Reset clears all stage valid bits and sets message_bits to 7.
// ----------------------------------------------------------------------------
module reed_muller_majority_decoder_top #(
    parameter int MAX_MESSAGE_BITS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rmmd_pkg::ADDR_W-1:0] paddr,
    input  logic [rmmd_pkg::DATA_W-1:0] pwdata,
    output logic [rmmd_pkg::DATA_W-1:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] received_word
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [6:0] message, [7] zero
);

    localparam int WORD_W = rmmd_pkg::WORD_W;
    localparam int MSG_W  = rmmd_pkg::MSG_W;
    localparam int N_W    = rmmd_pkg::N_W;
    localparam int PCW    = rmmd_pkg::PAIR_CNT_W;
    localparam int MCW    = rmmd_pkg::MIS_CNT_W;
    localparam int LEN_W  = rmmd_pkg::LEN_W;
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_MESSAGE_BITS);
    localparam logic [N_W-1:0] N_MIN = N_W'(2);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [N_W-1:0] n_cfg_reg;
    logic           cfg_sel;
    logic [N_W-1:0] n_eff;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == rmmd_pkg::REG_MESSAGE_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cfg_reg <= N_W'(7);
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            n_cfg_reg <= pwdata[N_W-1:0];
        end
    end

    assign prdata = cfg_sel ? rmmd_pkg::DATA_W'(n_cfg_reg) : '0;

    always_comb
    begin
        priority if (n_cfg_reg < N_MIN)
        begin
            n_eff = N_MIN;
        end
        else if (n_cfg_reg > N_MAX)
        begin
            n_eff = N_MAX;
        end
        else
        begin
            n_eff = n_cfg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage takes a new item when it is empty or its
    // content moves on in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: drop bits beyond the code length.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] w1_reg;
    logic [N_W-1:0]    n1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            w1_reg <= s_axis_tdata & rmmd_pkg::len_mask(n_eff);
            n1_reg <= n_eff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: count differing pairs for every message bit above bit 0.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] w2_reg;
    logic [N_W-1:0]    n2_reg;
    logic [PCW-1:0]    cnt2_reg [1:MSG_W-1];
    logic [PCW-1:0]    cnt2_next [1:MSG_W-1];

    always_comb
    begin
        for (int i = 1; i < MSG_W; i++)
        begin
            cnt2_next[i] = rmmd_pkg::popcount32(rmmd_pkg::pair_diff(w1_reg, i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            w2_reg    <= w1_reg;
            n2_reg    <= n1_reg;
            cnt2_reg  <= cnt2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: majority vote, then re-encode and mark mismatches.
    // ------------------------------------------------------------------
    logic [MSG_W-1:0]  msg3_reg, msg3_next;
    logic [WORD_W-1:0] mis3_reg, mis3_next;
    logic [N_W-1:0]    n3_reg;
    logic [LEN_W-1:0]  len2;

    assign len2 = rmmd_pkg::code_len(n2_reg);

    always_comb
    begin
        msg3_next    = '0;
        msg3_next[0] = w2_reg[0];
        for (int i = 1; i < MSG_W; i++)
        begin
            msg3_next[i] = (N_W'(i) < n2_reg) && (cnt2_reg[i] > PCW'(len2 >> 2));
        end
        mis3_next = (w2_reg ^ rmmd_pkg::encode(msg3_next)) & rmmd_pkg::len_mask(n2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            msg3_reg <= msg3_next;
            mis3_reg <= mis3_next;
            n3_reg   <= n2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: flip bit 0 when more than half the positions disagree.
    // ------------------------------------------------------------------
    logic [MSG_W-1:0] msg4_reg, msg4_next;
    logic [N_W-1:0]   n4_reg;
    logic [MCW-1:0]   mis_cnt;
    logic [LEN_W-1:0] len3;

    assign len3    = rmmd_pkg::code_len(n3_reg);
    assign mis_cnt = rmmd_pkg::popcount64(mis3_reg);

    always_comb
    begin
        msg4_next    = msg3_reg;
        msg4_next[0] = msg3_reg[0] ^ (mis_cnt > MCW'(len3 >> 1));
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            msg4_reg <= msg4_next;
            n4_reg   <= n3_reg;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {1'b0, msg4_reg};

`ifndef SYNTHESIS
    // Message bits at and above n must be zero on every delivered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ((msg4_reg >> n4_reg) == '0))
        else $error("decoded message has bits above message_bits");

    // The input side only stalls when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty pipeline stage");

    // A stage blocked by the next one keeps its item unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(msg3_reg) && $stable(mis3_reg)))
        else $error("stage 3 item lost during a stall");

    // An item in stage 1 moves on to stage 2 when nothing ahead of it stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && rdy2 && rdy3 && rdy4) |=> v2_reg)
        else $error("stage 1 item did not advance");
`endif

endmodule

// File: tb/rmmd_checker.sv
// ----------------------------------------------------------------------------
// rmmd_checker
// Watches the APB port and both streams of the Reed-Muller decoder, keeps its
// own copy of the message_bits register, predicts the decoded message for each
// accepted codeword and compares every output transfer against the oldest
// prediction. Register reads are checked against the tracked value.
// ----------------------------------------------------------------------------
module rmmd_checker #(
    parameter int MAX_MESSAGE_BITS = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rmmd_pkg::ADDR_W-1:0] paddr,
    input  logic [rmmd_pkg::DATA_W-1:0] pwdata,
    input  logic [rmmd_pkg::DATA_W-1:0] prdata,
    input  logic                        pready,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [rmmd_pkg::WORD_W-1:0] s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [7:0]                  m_axis_tdata,
    output int                          error_count,
    output int                          pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W = rmmd_pkg::WORD_W;
    localparam int MSG_W  = rmmd_pkg::MSG_W;
    localparam int N_W    = rmmd_pkg::N_W;
    localparam int ADDR_W = rmmd_pkg::ADDR_W;

    localparam logic [N_W-1:0] MSG_BITS_RESET = 3'd7;
    localparam int             REPORT_LIMIT   = 10;

    logic [N_W-1:0] msg_bits_q;
    logic [MSG_W-1:0] decoded_msgs[$];

    // Code position p carries m0 plus, for every j >= 1, mj times bit j-1 of p.
    function automatic logic [WORD_W-1:0] rm_encode(input logic [MSG_W-1:0] msg,
                                                    input int n, input int len);
        logic [WORD_W-1:0] cw;
        logic b;
        cw = '0;
        for (int p = 0; p < len; p++)
        begin
            b = msg[0];
            for (int j = 1; j < n; j++)
            begin
                b = b ^ (msg[j] & p[j-1]);
            end
            cw[p] = b;
        end
        return cw;
    endfunction

    function automatic logic [MSG_W-1:0] rm_decode(input logic [WORD_W-1:0] word,
                                                   input logic [N_W-1:0] n_reg);
        int n;
        int len;
        int e;
        int diff;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] w;
        logic [MSG_W-1:0] msg;
        n = int'(n_reg);
        if (n < 2) n = 2;
        if (n > MAX_MESSAGE_BITS) n = MAX_MESSAGE_BITS;
        len = 1 << (n - 1);
        mask = (len >= WORD_W) ? '1 : ((64'd1 << len) - 64'd1);
        w = word & mask;
        msg = '0;
        msg[0] = w[0];
        for (int i = 1; i < n; i++)
        begin
            e = 1 << (i - 1);
            diff = 0;
            for (int p = 0; p < len; p++)
            begin
                if ((p & e) == 0) diff += int'(w[p] ^ w[p + e]);
            end
            if (diff > (len >> 2)) msg[i] = 1'b1;
        end
        // A tie on the re-encoded distance keeps bit 0 as received.
        if ($countones((w ^ rm_encode(msg, n, len)) & mask) > (len >> 1))
            msg[0] = ~msg[0];
        return msg;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what,
                     exp_v, act_v);
    endtask

    initial
    begin
        error_count = 0;
        pending_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_bits_q <= MSG_BITS_RESET;
            decoded_msgs.delete();
            pending_count = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (paddr[ADDR_W-1:2] == rmmd_pkg::REG_MESSAGE_BITS && paddr[1:0] == 2'b00)
                begin
                    if (pwrite)
                        msg_bits_q <= pwdata[N_W-1:0];
                    else if (prdata[N_W-1:0] !== msg_bits_q)
                        note_mismatch("message_bits read", 64'(msg_bits_q),
                                      64'(prdata[N_W-1:0]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decoded_msgs.push_back(rm_decode(s_axis_tdata, msg_bits_q));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_msgs.size() == 0)
                    note_mismatch("unexpected message transfer", 64'(0),
                                  64'(m_axis_tdata));
                else if (m_axis_tdata !== {1'b0, decoded_msgs[0]})
                    note_mismatch("message", 64'({1'b0, decoded_msgs[0]}),
                                  64'(m_axis_tdata));
                if (decoded_msgs.size() != 0) void'(decoded_msgs.pop_front());
            end
            pending_count = decoded_msgs.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Reed-Muller majority-logic decoder. Runs a
// short directed set at the reset code length, then steps message_bits
// through every value (including the clamped ones and an ignored write to an
// unused address) with random codewords, mostly valid ones with a random
// number of bit errors and junk above the code length, plus pure noise.
// Both streams idle and stall at random; a separate checker does the scoring.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W = rmmd_pkg::ADDR_W;
    localparam int DATA_W = rmmd_pkg::DATA_W;
    localparam int WORD_W = rmmd_pkg::WORD_W;

    localparam int MAX_MESSAGE_BITS = 7;
    localparam int IDLE_LIMIT       = 2000;
    localparam int WORDS_PER_PHASE  = 158;
    localparam int PHASES           = 10;
    localparam int SPARE_REG_INDEX  = 1;

    localparam logic [ADDR_W-1:0] MSG_BITS_ADDR =
        ADDR_W'(rmmd_pkg::REG_MESSAGE_BITS) << 2;
    localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(SPARE_REG_INDEX) << 2;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata;   // [63:0] received_word
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // [6:0] message, [7] zero

    int  error_count;
    int  pending_count;
    int  idle_cycles;
    int  stall_left;
    bit  source_gaps;
    bit  sink_stalls;

    reed_muller_majority_decoder_top #(
        .MAX_MESSAGE_BITS(MAX_MESSAGE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rmmd_checker #(
        .MAX_MESSAGE_BITS(MAX_MESSAGE_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Generator rows of the code: row j marks positions whose bit j-1 is set.
    function automatic logic [WORD_W-1:0] gen_row(input int j);
        case (j)
            1:       return 64'hAAAA_AAAA_AAAA_AAAA;
            2:       return 64'hCCCC_CCCC_CCCC_CCCC;
            3:       return 64'hF0F0_F0F0_F0F0_F0F0;
            4:       return 64'hFF00_FF00_FF00_FF00;
            5:       return 64'hFFFF_0000_FFFF_0000;
            6:       return 64'hFFFF_FFFF_0000_0000;
            default: return '0;
        endcase
    endfunction

    function automatic int phase_setting(input int ph);
        case (ph)
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 3;
            4:       return 4;
            5:       return 5;
            6:       return 6;
            7:       return 7;
            8:       return 2;
            default: return 7;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] len_ones(input int len);
        return (len >= WORD_W) ? '1 : ((64'd1 << len) - 64'd1);
    endfunction

    // A valid codeword with a random number of flipped bits and junk above the
    // code length, or now and then plain noise.
    function automatic logic [WORD_W-1:0] rand_codeword(input int n, input int len);
        logic [WORD_W-1:0] cw;
        logic [WORD_W-1:0] noise;
        int errs;
        noise = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 3) return noise;
        cw = $urandom_range(0, 1) ? '1 : '0;
        for (int j = 1; j < n; j++)
        begin
            if ($urandom_range(0, 1)) cw = cw ^ gen_row(j);
        end
        if ($urandom_range(0, 1))
            errs = $urandom_range(0, len / 4);
        else
            errs = $urandom_range(len / 4, len / 2 + 1);
        repeat (errs) cw = cw ^ (64'd1 << $urandom_range(0, len - 1));
        return (cw & len_ones(len)) | (noise & ~len_ones(len));
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        gap = (source_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Returns the bus to idle before it ends, so that back-to-back calls
    // never drive the bus twice in the same time step.
    task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every decoded message has come back before returning.
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 3) == 0)
        begin
            stall_left    <= idle_len() - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int len;
        int setting;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_cycles   = 0;
        stall_left    = 0;
        source_gaps   = 1'b0;
        sink_stalls   = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset length of 64: extremes, pure generator rows and the tie cases.
        apb_xfer(1'b0, MSG_BITS_ADDR, '0);
        send_word('0);
        send_word('1);
        for (int j = 1; j < MAX_MESSAGE_BITS; j++) send_word(gen_row(j));
        send_word(~gen_row(1));
        send_word(64'h8000_0000_0000_0001);
        send_word(64'h0000_0000_FFFF_FFFF);
        send_word(gen_row(1) ^ 64'h0000_0000_0000_FFFF);
        send_word(gen_row(3) ^ 64'h0000_0000_0001_FFFF);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pipe();
            setting = phase_setting(ph);
            // A write to an unused register must leave message_bits alone.
            if (ph == 5) apb_xfer(1'b1, SPARE_ADDR, {$urandom} & ~32'h7 | 32'h2);
            apb_xfer(1'b1, MSG_BITS_ADDR, ({$urandom} & ~32'h7) | DATA_W'(setting));
            apb_xfer(1'b0, MSG_BITS_ADDR, '0);
            source_gaps = (ph % 3 != 0);
            sink_stalls = (ph % 4 != 1);
            n = (setting < 2) ? 2 : setting;
            len = 1 << (n - 1);
            // Junk above the code length plus bit 63; the junk must be ignored.
            send_word(~len_ones(len) | 64'h8000_0000_0000_0000);
            repeat (WORDS_PER_PHASE) send_word(rand_codeword(n, len));
        end

        drain_pipe();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: reed_muller_majority_decoder_top.f
hdl/rmmd_pkg.sv
hdl/reed_muller_majority_decoder_top.sv
tb/rmmd_checker.sv
tb/tb.sv
